### rtl/cle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

  // Command codes carried in the kind field of a request
  typedef enum logic [1:0] {
    KIND_LEFT  = 2'd0,
    KIND_RIGHT = 2'd1,
    KIND_DEL   = 2'd2,
    KIND_INS   = 2'd3
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic take;        // latch a new request
    logic cur_dec;     // cursor one step left
    logic cur_inc;     // cursor one step right
    logic set_drop;    // insert refused, line full
    logic shift_init;  // load shift pointer for the latched command
    logic shift_rd;    // one shift move: read at pointer, write in the following cycle
    logic upd_del;     // finish a delete: length and cursor
    logic upd_ins;     // finish an insert: write byte, length and cursor
    logic emit_init;   // pointer back to the first character
    logic emit_rd;     // stream the line out
  } cle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;         // latched command
    logic  len_zero;     // line is empty
    logic  full;         // line holds DEPTH characters
    logic  cur_first;    // cursor on the first character
    logic  cur_lastpos;  // cursor on the last character
    logic  shift_last;   // current shift move is the final one
    logic  emit_end;     // final result of the line issued this cycle
    logic  s1_busy;      // read stage still holds a result
  } cle_sts_t;

endpackage

`default_nettype wire

### rtl/cle_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one edit command
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] ch;

  modport source (output valid, output kind, output ch, input ready);
  modport sink   (input valid, input kind, input ch, output ready);
endinterface

// Result channel: one character of the line
interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       at_cursor;
  logic       line_empty;
  logic       last;
  logic       dropped;

  modport source (output valid, output out_char, output at_cursor, output line_empty,
                  output last, output dropped, input ready);
  modport sink   (input valid, input out_char, input at_cursor, input line_empty,
                  input last, input dropped, output ready);
endinterface

`default_nettype wire

### rtl/cle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cle_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cle_pkg::cle_sts_t sts,
  output cle_pkg::cle_cmd_t     cmd
);
  import cle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_FLUSH,
    S_UPDATE,
    S_EMIT,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (sts.kind)
          KIND_LEFT: begin
            cmd.cur_dec   = !sts.len_zero && !sts.cur_first;
            cmd.emit_init = 1'b1;
            state_nxt     = S_EMIT;
          end
          KIND_RIGHT: begin
            cmd.cur_inc   = !sts.len_zero && !sts.cur_lastpos;
            cmd.emit_init = 1'b1;
            state_nxt     = S_EMIT;
          end
          KIND_DEL: begin
            if (sts.len_zero) begin
              cmd.emit_init = 1'b1;
              state_nxt     = S_EMIT;
            end else if (sts.cur_lastpos) begin
              state_nxt = S_UPDATE;
            end else begin
              cmd.shift_init = 1'b1;
              state_nxt      = S_SHIFT;
            end
          end
          KIND_INS: begin
            if (sts.full) begin
              cmd.set_drop  = 1'b1;
              cmd.emit_init = 1'b1;
              state_nxt     = S_EMIT;
            end else if (sts.len_zero || sts.cur_lastpos) begin
              state_nxt = S_UPDATE;
            end else begin
              cmd.shift_init = 1'b1;
              state_nxt      = S_SHIFT;
            end
          end
          default: begin
            cmd.emit_init = 1'b1;
            state_nxt     = S_EMIT;
          end
        endcase
      end
      S_SHIFT: begin
        cmd.shift_rd = 1'b1;
        if (sts.shift_last) state_nxt = S_FLUSH;
      end
      // last pending shift write lands here
      S_FLUSH: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.upd_del   = (sts.kind == KIND_DEL);
        cmd.upd_ins   = (sts.kind == KIND_INS);
        cmd.emit_init = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_rd = 1'b1;
        if (sts.emit_end) state_nxt = S_DRAIN;
      end
      // read stage must empty before the next request may reuse the read port
      S_DRAIN: begin
        if (!sts.s1_busy) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

### rtl/cle_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module cle_dp #(
  parameter int DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        in_kind,
  input  wire logic [7:0]        in_ch,
  input  wire cle_pkg::cle_cmd_t cmd,
  output cle_pkg::cle_sts_t      sts,
  cle_out_if.source              out_chan
);
  import cle_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  // Line storage
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Control state
  logic [LW-1:0] len_r, len_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          pend_v_r;
  logic [AW-1:0] pend_a_r;
  kind_t         kind_r;
  logic [7:0]    ch_r;
  logic          drop_r, drop_nxt;

  // Read stage and output register
  logic s1_v_r, s1_v_nxt;
  logic s1_cur_r, s1_last_r, s1_empty_r, s1_drop_r;
  logic out_v_r, out_v_nxt;
  logic [7:0] out_char_r;
  logic out_cur_r, out_last_r, out_empty_r, out_drop_r;

  logic          is_del;
  logic          adv;
  logic          issue;
  logic          emit_last;
  logic          rd_en;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  logic [AW-1:0] cur_p1;

  // Status
  assign is_del          = (kind_r == KIND_DEL);
  assign cur_p1          = cur_r + AW'(1);
  assign sts.kind        = kind_r;
  assign sts.len_zero    = (len_r == '0);
  assign sts.full        = (len_r == LW'(DEPTH));
  assign sts.cur_first   = (cur_r == '0);
  assign sts.cur_lastpos = ((LW'(cur_r) + LW'(1)) == len_r);
  assign sts.shift_last  = is_del ? ((LW'(ptr_r) + LW'(1)) == len_r) : (ptr_r == cur_p1);
  assign emit_last       = sts.len_zero || ((LW'(ptr_r) + LW'(1)) == len_r);
  assign sts.emit_end    = issue && emit_last;
  assign sts.s1_busy     = s1_v_r;

  // Result pipeline advance
  assign adv   = !out_v_r || out_chan.ready;
  assign issue = cmd.emit_rd && adv;
  assign rd_en = issue || cmd.shift_rd;

  // Write port: pending shift move or the inserted byte
  always_comb begin
    we = 1'b0;
    wa = pend_a_r;
    wd = rdata_r;
    if (pend_v_r) begin
      we = 1'b1;
    end else if (cmd.upd_ins) begin
      we = 1'b1;
      wa = sts.len_zero ? '0 : cur_p1;
      wd = ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rdata_r <= mem[ptr_r];
  end

  // Length, cursor, pointer
  always_comb begin
    len_nxt  = len_r;
    cur_nxt  = cur_r;
    ptr_nxt  = ptr_r;
    drop_nxt = drop_r;
    if (cmd.take) drop_nxt = 1'b0;
    if (cmd.set_drop) drop_nxt = 1'b1;
    if (cmd.cur_dec) cur_nxt = cur_r - AW'(1);
    if (cmd.cur_inc) cur_nxt = cur_p1;
    if (cmd.upd_del) begin
      len_nxt = len_r - LW'(1);
      if (sts.cur_lastpos && !sts.cur_first) cur_nxt = cur_r - AW'(1);
    end
    if (cmd.upd_ins) begin
      len_nxt = len_r + LW'(1);
      cur_nxt = sts.len_zero ? '0 : cur_p1;
    end
    if (cmd.shift_init) ptr_nxt = is_del ? cur_p1 : AW'(len_r - LW'(1));
    if (cmd.shift_rd) ptr_nxt = is_del ? (ptr_r + AW'(1)) : (ptr_r - AW'(1));
    if (cmd.emit_init) ptr_nxt = '0;
    if (issue) ptr_nxt = ptr_r + AW'(1);
  end

  always_comb begin
    s1_v_nxt  = adv ? issue : s1_v_r;
    out_v_nxt = adv ? s1_v_r : out_v_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      cur_r    <= '0;
      ptr_r    <= '0;
      pend_v_r <= 1'b0;
      drop_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      len_r    <= len_nxt;
      cur_r    <= cur_nxt;
      ptr_r    <= ptr_nxt;
      pend_v_r <= cmd.shift_rd;
      drop_r   <= drop_nxt;
      s1_v_r   <= s1_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r <= kind_t'(in_kind);
      ch_r   <= in_ch;
    end
    if (cmd.shift_rd) pend_a_r <= is_del ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
    if (issue) begin
      s1_cur_r   <= !sts.len_zero && (ptr_r == cur_r);
      s1_last_r  <= emit_last;
      s1_empty_r <= sts.len_zero;
      s1_drop_r  <= drop_r;
    end
    if (adv && s1_v_r) begin
      out_char_r  <= s1_empty_r ? 8'd0 : rdata_r;
      out_cur_r   <= s1_cur_r;
      out_last_r  <= s1_last_r;
      out_empty_r <= s1_empty_r;
      out_drop_r  <= s1_drop_r;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.out_char   = out_char_r;
  assign out_chan.at_cursor  = out_cur_r;
  assign out_chan.line_empty = out_empty_r;
  assign out_chan.last       = out_last_r;
  assign out_chan.dropped    = out_drop_r;

`ifndef SYNTHESIS
  a_cur_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) |-> (LW'(cur_r) < len_r))
    else $error("cursor beyond end of line");

  a_empty_cur_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) |-> (cur_r == '0))
    else $error("cursor not at zero on empty line");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(DEPTH))
    else $error("line length above depth");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_v_r && cmd.upd_ins))
    else $error("shift write collides with insert write");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> (s1_v_r && $stable(rdata_r)))
    else $error("read stage lost data under backpressure");
`endif

endmodule

`default_nettype wire

### rtl/cursor_line_edit_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

// One request at a time: each request, edit or not, gives r results (r = line length, or one
// when empty), and the next request is accepted only after the read stage has drained.
// A move, a refused insert or a delete on an empty line goes straight to the results; any
// other edit passes an update step, and a shifting edit first moves each shifted character
// in memory and then passes a flush step. Sink stalls hold the results and delay the next accept.
// Synchronous active-low reset empties the line and the cursor; memory is not cleared.
module cursor_line_edit_buffer #(
  parameter int DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cle_in_if.sink     in_chan,
  cle_out_if.source  out_chan
);
  import cle_pkg::*;

  cle_cmd_t cmd;
  cle_sts_t sts;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_kind  (in_chan.kind),
    .in_ch    (in_chan.ch),
    .cmd      (cmd),
    .sts      (sts),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
